// File: rtl/fat_chain_table_engine_core_assert.svh
// ----------------------------------------------------------------------------
// fat chain table engine assertion macros
// concurrent assertion helpers used by fat_chain_table_engine_core
// ----------------------------------------------------------------------------
`ifndef FAT_CHAIN_TABLE_ENGINE_CORE_ASSERT_SVH
`define FAT_CHAIN_TABLE_ENGINE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// property holds in the same cycle
`define FCTE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fcte assertion failed");
// consequent holds in the cycle after the antecedent
`define FCTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcte assertion failed");
`else
`define FCTE_ASSERT(label, clk, rst, prop)
`define FCTE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/fcte_pkg.sv
// ----------------------------------------------------------------------------
// fcte package
// sizes, codes and types of the chain table engine
// ----------------------------------------------------------------------------
package fcte_pkg;
   localparam int ENTRIES    = 64;
   localparam int BLOCK_BITS = 16;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int GROUPS     = (ENTRIES + 7) / 8;
   localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int BLK_RAM_W  = BLOCK_BITS + 1;
   localparam int LNK_RAM_W  = 7;

   typedef logic [BLOCK_BITS-1:0] blk_type;

   typedef enum logic [2:0] {
      MODE_CREATE = 3'd0,
      MODE_TAIL   = 3'd1,
      MODE_READ   = 3'd2,
      MODE_LINK   = 3'd3,
      MODE_ASSIGN = 3'd4,
      MODE_FREE   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_UNUSED  = 2'd2,
      STAT_TOOLONG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOOK,
      ST_SCAN
   } state_type;
endpackage

// File: rtl/fcte_req_if.sv
// ----------------------------------------------------------------------------
// fcte request channel
// valid/ready channel carrying one operation beat
// ----------------------------------------------------------------------------
interface fcte_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [5:0]  entry_index;
   logic [5:0]  link_value;
   logic        link_is_end;
   logic [15:0] free_block;
   logic        free_block_ok;

   modport source (output valid, mode, entry_index, link_value, link_is_end,
                   free_block, free_block_ok, input ready);
   modport sink (input valid, mode, entry_index, link_value, link_is_end,
                 free_block, free_block_ok, output ready);
endinterface

// File: rtl/fcte_rsp_if.sv
// ----------------------------------------------------------------------------
// fcte response channel
// valid/ready channel carrying one result beat
// ----------------------------------------------------------------------------
interface fcte_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  index_out;
   logic [15:0] block_out;
   logic        block_valid;
   logic [5:0]  next_out;
   logic        next_is_end;
   logic        freed_valid;
   logic        last;

   modport source (output valid, status, index_out, block_out, block_valid,
                   next_out, next_is_end, freed_valid, last, input ready);
   modport sink (input valid, status, index_out, block_out, block_valid,
                 next_out, next_is_end, freed_valid, last, output ready);
endinterface

// File: rtl/fat_chain_table_engine_core.sv
// ----------------------------------------------------------------------------
// fat chain table engine core
// chain entry table with create, tail, read, link, assign and free operations
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  req_bus   in   one operation (mode, entry, link, free block)
//  rsp_bus   out  one result; free chain gives one per freed entry, last on final
//  csr_*     in   block offset write
//
// one item at a time; link and assign finish in the decode state, while read,
// tail and free first read the root entry; create scans eight used bits per
// cycle, tail follows the chain link by link, free gives one result per freed
// entry, the walks paced by the registered read of the entry memories
// reset clears used bits and the offset at once; entry memories need no clear
// a stalled result holds the walk in place, the next item waits for idle
`include "fat_chain_table_engine_core_assert.svh"

module fat_chain_table_engine_core
   import fcte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   fcte_req_if.sink    req_bus,
   fcte_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   state_type state_ff, state_in;

   // latched operation
   mode_type    mode_ff, mode_in;
   logic [5:0]  idx_ff, idx_in;
   logic [5:0]  link_ff, link_in;
   logic        lend_ff, lend_in;
   logic [15:0] fblk_ff, fblk_in;
   logic        fok_ff, fok_in;

   // walk state
   logic [5:0]       cur_ff, cur_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [GRP_W-1:0] grp_ff, grp_in;

   logic [ENTRIES-1:0] used_ff, used_in;
   logic [15:0]        offset_ff;

   // result register
   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic [5:0]  rsp_index_ff;
   logic [15:0] rsp_block_ff;
   logic        rsp_bv_ff;
   logic [5:0]  rsp_next_ff;
   logic        rsp_nend_ff;
   logic        rsp_freed_ff;
   logic        rsp_last_ff;

   logic        emit;
   status_type  e_status;
   logic [5:0]  e_index;
   logic [15:0] e_block;
   logic        e_bv;
   logic [5:0]  e_next;
   logic        e_nend;
   logic        e_freed;
   logic        e_last;

   // memories
   logic                 blk_we, lnk_we;
   logic [IDX_W-1:0]     blk_wa, lnk_wa;
   logic [BLK_RAM_W-1:0] blk_wd, blk_rd;
   logic [LNK_RAM_W-1:0] lnk_wd, lnk_rd;
   logic [IDX_W-1:0]     rd_addr;

   logic req_accept;
   logic out_free;

   // current entry fields from memory
   blk_type    cur_block;
   logic       cur_bv;
   logic [5:0] cur_next;
   logic       cur_end;

   // free entry search
   logic [GROUPS*8-1:0] free_vec;
   logic [7:0]          free_grp [GROUPS];
   logic [7:0]          grp_bits;
   logic [2:0]          lane;
   logic                lane_hit;
   blk_type             sum_blk;

   function automatic logic in_use(input logic [5:0] x, input logic [ENTRIES-1:0] u);
      logic ok;
      ok = (7'(x) < 7'(ENTRIES)) && u[x[IDX_W-1:0]];
      return ok;
   endfunction

   assign req_accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign cur_block = blk_rd[BLOCK_BITS-1:0];
   assign cur_bv    = blk_rd[BLOCK_BITS];
   assign cur_next  = lnk_rd[5:0];
   assign cur_end   = lnk_rd[6];
   assign sum_blk   = blk_type'(32'(fblk_ff) + 32'(offset_ff));

   // lowest free entry within the scanned group of eight
   always_comb begin
      free_vec = '0;
      free_vec[ENTRIES-1:0] = ~used_ff;
      for (int g = 0; g < GROUPS; g++) begin
         free_grp[g] = free_vec[g*8 +: 8];
      end
      grp_bits = free_grp[grp_ff];
      lane     = '0;
      lane_hit = 1'b0;
      for (int l = 7; l >= 0; l--) begin
         if (grp_bits[l]) begin
            lane     = 3'(l);
            lane_hit = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      link_in  = link_ff;
      lend_in  = lend_ff;
      fblk_in  = fblk_ff;
      fok_in   = fok_ff;
      cur_in   = cur_ff;
      cnt_in   = cnt_ff;
      grp_in   = grp_ff;
      used_in  = used_ff;

      emit     = 1'b0;
      e_status = STAT_OK;
      e_index  = '0;
      e_block  = '0;
      e_bv     = 1'b0;
      e_next   = '0;
      e_nend   = 1'b0;
      e_freed  = 1'b0;
      e_last   = 1'b1;

      blk_we = 1'b0;
      blk_wa = idx_ff[IDX_W-1:0];
      blk_wd = '0;
      lnk_we = 1'b0;
      lnk_wa = idx_ff[IDX_W-1:0];
      lnk_wd = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in  = mode_type'(req_bus.mode);
               idx_in   = req_bus.entry_index;
               link_in  = req_bus.link_value;
               lend_in  = req_bus.link_is_end;
               fblk_in  = req_bus.free_block;
               fok_in   = req_bus.free_block_ok;
               cur_in   = req_bus.entry_index;
               cnt_in   = '0;
               grp_in   = '0;
               // unknown modes are dropped without a result
               if (req_bus.mode <= 3'(MODE_FREE)) begin
                  state_in = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            if (mode_ff == MODE_CREATE) begin
               state_in = ST_SCAN;
            end else if (!in_use(idx_ff, used_ff)) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_status = STAT_UNUSED;
                  if (mode_ff == MODE_TAIL || mode_ff == MODE_FREE) begin
                     e_index = idx_ff;
                  end
                  state_in = ST_IDLE;
               end
            end else if (mode_ff == MODE_LINK) begin
               if (out_free) begin
                  lnk_we   = 1'b1;
                  lnk_wd   = {lend_ff, link_ff};
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (mode_ff == MODE_ASSIGN) begin
               if (out_free) begin
                  emit = 1'b1;
                  if (!fok_ff) begin
                     e_status = STAT_NOSPACE;
                  end else begin
                     blk_we  = 1'b1;
                     blk_wd  = {1'b1, sum_blk};
                     e_block = 16'(sum_blk);
                     e_bv    = 1'b1;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               // read of the root entry is in flight
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            case (mode_ff)
               MODE_READ: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_block  = 16'(cur_block);
                     e_bv     = cur_bv;
                     e_next   = cur_next;
                     e_nend   = cur_end;
                     state_in = ST_IDLE;
                  end
               end
               MODE_TAIL: begin
                  if (cur_end) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_index  = cur_ff;
                        state_in = ST_IDLE;
                     end
                  end else if (cnt_ff >= CNT_W'(ENTRIES - 1)) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_status = STAT_TOOLONG;
                        e_index  = cur_ff;
                        state_in = ST_IDLE;
                     end
                  end else if (!in_use(cur_next, used_ff)) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_status = STAT_UNUSED;
                        e_index  = cur_next;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     // follow one link per cycle
                     cur_in = cur_next;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               MODE_FREE: begin
                  if (out_free) begin
                     used_in[cur_ff[IDX_W-1:0]] = 1'b0;
                     emit    = 1'b1;
                     e_index = cur_ff;
                     e_block = 16'(cur_block);
                     e_bv    = cur_bv;
                     e_freed = cur_bv;
                     if (cur_end) begin
                        state_in = ST_IDLE;
                     end else if (!in_use(cur_next, used_ff) || cur_next == cur_ff ||
                                  (cnt_ff + 1'b1) >= CNT_W'(ENTRIES)) begin
                        // broken or cyclic chain
                        e_status = STAT_UNUSED;
                        state_in = ST_IDLE;
                     end else begin
                        e_last = 1'b0;
                        cur_in = cur_next;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (lane_hit) begin
               if (out_free) begin
                  used_in[IDX_W'(32'(grp_ff) * 8 + 32'(lane))] = 1'b1;
                  blk_we   = 1'b1;
                  blk_wa   = IDX_W'(32'(grp_ff) * 8 + 32'(lane));
                  blk_wd   = '0;
                  lnk_we   = 1'b1;
                  lnk_wa   = IDX_W'(32'(grp_ff) * 8 + 32'(lane));
                  lnk_wd   = {1'b1, 6'd0};
                  emit     = 1'b1;
                  e_index  = 6'(32'(grp_ff) * 8 + 32'(lane));
                  state_in = ST_IDLE;
               end
            end else if (32'(grp_ff) == GROUPS - 1) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_status = STAT_NOSPACE;
                  state_in = ST_IDLE;
               end
            end else begin
               grp_in = grp_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = cur_in[IDX_W-1:0];

   fcte_ram #(.WIDTH(BLK_RAM_W), .DEPTH(ENTRIES)) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (blk_wa),
      .wr_data (blk_wd),
      .rd_addr (rd_addr),
      .rd_data (blk_rd)
   );

   fcte_ram #(.WIDTH(LNK_RAM_W), .DEPTH(ENTRIES)) u_lnk_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_wa),
      .wr_data (lnk_wd),
      .rd_addr (rd_addr),
      .rd_data (lnk_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      idx_ff  <= idx_in;
      link_ff <= link_in;
      lend_ff <= lend_in;
      fblk_ff <= fblk_in;
      fok_ff  <= fok_in;
      cur_ff  <= cur_in;
      cnt_ff  <= cnt_in;
      grp_ff  <= grp_in;
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_index_ff  <= e_index;
         rsp_block_ff  <= e_block;
         rsp_bv_ff     <= e_bv;
         rsp_next_ff   <= e_next;
         rsp_nend_ff   <= e_nend;
         rsp_freed_ff  <= e_freed;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.index_out   = rsp_index_ff;
   assign rsp_bus.block_out   = rsp_block_ff;
   assign rsp_bus.block_valid = rsp_bv_ff;
   assign rsp_bus.next_out    = rsp_next_ff;
   assign rsp_bus.next_is_end = rsp_nend_ff;
   assign rsp_bus.freed_valid = rsp_freed_ff;
   assign rsp_bus.last        = rsp_last_ff;

   // a waiting result is never overwritten by a new one
   `FCTE_ASSERT(a_no_overwrite, clock, reset, !(emit && rsp_valid_ff && !rsp_bus.ready))
   // walk counter never reaches the table size
   `FCTE_ASSERT(a_walk_bound, clock, reset, !(state_ff == ST_LOOK) || (cnt_ff < CNT_W'(ENTRIES)))
   // an unknown mode leaves the engine idle
   `FCTE_ASSERT_NEXT(a_drop_mode, clock, reset, req_accept && (req_bus.mode > 3'(MODE_FREE)), state_ff == ST_IDLE)
endmodule

// File: rtl/fcte_ram.sv
// ----------------------------------------------------------------------------
// fcte ram
// simple dual port memory, one write and one registered read port
// ----------------------------------------------------------------------------
module fcte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: verif/fcte_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcte testbench channel notes
// the channels themselves come from the rtl interfaces fcte_req_if and
// fcte_rsp_if; this file carries the shared beat types of the bench
// ----------------------------------------------------------------------------
package fcte_tb_pkg;
   import fcte_pkg::*;

   typedef struct packed {
      logic [2:0]  mode;
      logic [5:0]  entry_index;
      logic [5:0]  link_value;
      logic        link_is_end;
      logic [15:0] free_block;
      logic        free_block_ok;
   } op_beat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  index_out;
      logic [15:0] block_out;
      logic        block_valid;
      logic [5:0]  next_out;
      logic        next_is_end;
      logic        freed_valid;
      logic        last;
   } result_beat_type;
endpackage

// File: verif/tb_fat_chain_table_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chain table engine testbench
// drives operation beats with random gaps, keeps a shadow copy of the chain
// table, and compares every result beat with the shadow's prediction
// ----------------------------------------------------------------------------
module tb_fat_chain_table_engine_core;
   import fcte_pkg::*;
   import fcte_tb_pkg::*;

   localparam int NUM_RANDOM = 325;
   localparam logic [2:0] MODE_BAD = 3'd6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   fcte_req_if req_bus ();
   fcte_rsp_if rsp_bus ();

   fat_chain_table_engine_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // shadow table
   logic        sh_used [ENTRIES];
   logic [15:0] sh_block [ENTRIES];
   logic        sh_bv [ENTRIES];
   logic [5:0]  sh_next [ENTRIES];
   logic        sh_end [ENTRIES];
   logic [15:0] sh_offset;

   result_beat_type pending_results[$];
   int error_count = 0;
   bit rsp_stall_en = 1'b1;

   task automatic report_mismatch(input string what, input result_beat_type got,
                                  input result_beat_type want);
      error_count++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic result_beat_type mk(input logic [1:0] st, input logic [5:0] ix,
                                          input logic [15:0] bk, input logic bv,
                                          input logic [5:0] nx, input logic ne,
                                          input logic fv, input logic lst);
      result_beat_type r;
      r = '{st, ix, bk, bv, nx, ne, fv, lst};
      return r;
   endfunction

   // work out the result beats of one operation and update the shadow
   task automatic predict_chain_op(input op_beat_type op);
      int i;
      int steps;
      int k;
      logic [5:0] cur;
      logic [5:0] nx;
      logic [15:0] b;
      if (op.mode == MODE_CREATE) begin
         for (i = 0; i < ENTRIES; i++)
            if (!sh_used[i]) break;
         if (i >= ENTRIES) begin
            pending_results.push_back(mk(STAT_NOSPACE, 0, 0, 0, 0, 0, 0, 1));
         end else begin
            sh_used[i] = 1; sh_block[i] = 0; sh_bv[i] = 0;
            sh_next[i] = 0; sh_end[i] = 1;
            pending_results.push_back(mk(STAT_OK, i[5:0], 0, 0, 0, 0, 0, 1));
         end
         return;
      end
      if (op.mode > MODE_FREE) return;   // ignored, no result
      if (!sh_used[op.entry_index]) begin
         pending_results.push_back(mk(STAT_UNUSED,
            (op.mode == MODE_TAIL || op.mode == MODE_FREE) ? op.entry_index : 6'd0,
            0, 0, 0, 0, 0, 1));
         return;
      end
      case (op.mode)
         MODE_TAIL: begin
            cur = op.entry_index;
            steps = 0;
            while (!sh_end[cur]) begin
               nx = sh_next[cur];
               if (steps >= ENTRIES - 1) begin
                  pending_results.push_back(mk(STAT_TOOLONG, cur, 0, 0, 0, 0, 0, 1));
                  return;
               end
               if (!sh_used[nx]) begin
                  pending_results.push_back(mk(STAT_UNUSED, nx, 0, 0, 0, 0, 0, 1));
                  return;
               end
               cur = nx;
               steps++;
            end
            pending_results.push_back(mk(STAT_OK, cur, 0, 0, 0, 0, 0, 1));
         end
         MODE_READ: begin
            cur = op.entry_index;
            pending_results.push_back(mk(STAT_OK, 0, sh_block[cur], sh_bv[cur],
                                         sh_next[cur], sh_end[cur], 0, 1));
         end
         MODE_LINK: begin
            sh_next[op.entry_index] = op.link_value;
            sh_end[op.entry_index] = op.link_is_end;
            pending_results.push_back(mk(STAT_OK, 0, 0, 0, 0, 0, 0, 1));
         end
         MODE_ASSIGN: begin
            if (!op.free_block_ok) begin
               pending_results.push_back(mk(STAT_NOSPACE, 0, 0, 0, 0, 0, 0, 1));
            end else begin
               b = op.free_block + sh_offset;   // wraps at 16 bits
               sh_block[op.entry_index] = b;
               sh_bv[op.entry_index] = 1;
               pending_results.push_back(mk(STAT_OK, 0, b, 1, 0, 0, 0, 1));
            end
         end
         default: begin   // free chain
            cur = op.entry_index;
            k = 0;
            forever begin
               sh_used[cur] = 0;
               if (sh_end[cur]) begin
                  pending_results.push_back(mk(STAT_OK, cur, sh_block[cur], sh_bv[cur],
                                               0, 0, sh_bv[cur], 1));
                  return;
               end
               nx = sh_next[cur];
               if (!sh_used[nx] || k + 1 >= ENTRIES) begin
                  pending_results.push_back(mk(STAT_UNUSED, cur, sh_block[cur],
                                               sh_bv[cur], 0, 0, sh_bv[cur], 1));
                  return;
               end
               pending_results.push_back(mk(STAT_OK, cur, sh_block[cur], sh_bv[cur],
                                            0, 0, sh_bv[cur], 0));
               k++;
               cur = nx;
            end
         end
      endcase
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // send one beat; the prediction is made when the beat is accepted
   task automatic send_op(input op_beat_type op);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= op.mode;
      req_bus.entry_index <= op.entry_index;
      req_bus.link_value <= op.link_value;
      req_bus.link_is_end <= op.link_is_end;
      req_bus.free_block <= op.free_block;
      req_bus.free_block_ok <= op.free_block_ok;
      do @(posedge clock); while (!req_bus.ready);
      predict_chain_op(op);
   endtask

   // wait for an empty scoreboard, then let a trailing free walk settle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
   endtask

   task automatic write_offset(input logic [15:0] value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sh_offset = value;
   endtask

   function automatic op_beat_type mk_op(input logic [2:0] md, input logic [5:0] ix,
                                         input logic [5:0] lv, input logic le,
                                         input logic [15:0] fb, input logic fok);
      op_beat_type o;
      o = '{md, ix, lv, le, fb, fok};
      return o;
   endfunction

   // pick an entry: mostly a used one so that chains get built
   function automatic logic [5:0] pick_entry();
      int tries;
      logic [5:0] e;
      for (tries = 0; tries < 8; tries++) begin
         e = 6'($urandom_range(0, ENTRIES - 1));
         if (sh_used[e]) return e;
      end
      return 6'($urandom_range(0, ENTRIES - 1));
   endfunction

   // result side: random stalls, compare against oldest prediction
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            result_beat_type got;
            result_beat_type want;
            got = '{rsp_bus.status, rsp_bus.index_out, rsp_bus.block_out,
                    rsp_bus.block_valid, rsp_bus.next_out, rsp_bus.next_is_end,
                    rsp_bus.freed_valid, rsp_bus.last};
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat", got, '0);
            end else begin
               want = pending_results.pop_front();
               if (got != want) report_mismatch("result", got, want);
            end
         end
         if (!rsp_stall_en) begin
            hold = 0;
            rsp_bus.ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < 30) begin
            hold = gap_len();
            rsp_bus.ready <= (hold == 0);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // directed rows: expected value typed in where it is obvious
   typedef struct {
      op_beat_type     op;
      bit              has_want;
      result_beat_type want;
   } dir_row_type;

   initial begin : stimulus
      dir_row_type rows[$];
      op_beat_type op;
      int n;
      int r;
      for (int i = 0; i < ENTRIES; i++) begin
         sh_used[i] = 0; sh_block[i] = 0; sh_bv[i] = 0; sh_next[i] = 0; sh_end[i] = 0;
      end
      sh_offset = 0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_CREATE;
      req_bus.entry_index = '0;
      req_bus.link_value = '0;
      req_bus.link_is_end = 1'b0;
      req_bus.free_block = '0;
      req_bus.free_block_ok = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: table empty
      rows.push_back('{mk_op(MODE_READ, 0, 0, 0, 0, 0), 1,
                       mk(STAT_UNUSED, 0, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{mk_op(MODE_TAIL, 63, 0, 0, 0, 0), 1,
                       mk(STAT_UNUSED, 63, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{mk_op(MODE_FREE, 17, 0, 0, 0, 0), 1,
                       mk(STAT_UNUSED, 17, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{mk_op(MODE_CREATE, 0, 0, 0, 0, 0), 1,
                       mk(STAT_OK, 0, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{mk_op(MODE_CREATE, 0, 0, 0, 0, 0), 1,
                       mk(STAT_OK, 1, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{mk_op(MODE_CREATE, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(MODE_READ, 0, 0, 0, 0, 0), 1,
                       mk(STAT_OK, 0, 0, 0, 0, 1, 0, 1)});
      rows.push_back('{mk_op(MODE_ASSIGN, 0, 0, 0, 16'hFFFF, 0), 1,
                       mk(STAT_NOSPACE, 0, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{mk_op(MODE_ASSIGN, 0, 0, 0, 16'hFFFF, 1), 1,
                       mk(STAT_OK, 0, 16'hFFFF, 1, 0, 0, 0, 1)});
      rows.push_back('{mk_op(MODE_ASSIGN, 1, 0, 0, 0, 1), 0, '0});
      rows.push_back('{mk_op(MODE_LINK, 0, 1, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(MODE_LINK, 1, 2, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(MODE_TAIL, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(MODE_LINK, 2, 0, 0, 0, 0), 0, '0});  // cycle
      rows.push_back('{mk_op(MODE_TAIL, 0, 0, 0, 0, 0), 0, '0});  // walk too long
      rows.push_back('{mk_op(MODE_LINK, 2, 63, 0, 0, 0), 0, '0}); // link to an unused entry
      rows.push_back('{mk_op(MODE_TAIL, 1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(MODE_READ, 2, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(MODE_LINK, 2, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(MODE_FREE, 0, 0, 0, 0, 0), 0, '0});  // frees back into itself
      rows.push_back('{mk_op(MODE_BAD, 5, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(3'd7, 5, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk_op(MODE_LINK, 40, 63, 1, 0, 0), 1,
                       mk(STAT_UNUSED, 0, 0, 0, 0, 0, 0, 1)});

      foreach (rows[i]) begin
         send_op(rows[i].op);
         if (rows[i].has_want && pending_results.size() > 0 &&
             pending_results[pending_results.size() - 1] != rows[i].want)
            report_mismatch("directed row", pending_results[pending_results.size() - 1],
                            rows[i].want);
      end

      // fill the table to the brim, then one more create for out of space
      drain_results();
      for (n = 0; n < ENTRIES + 1; n++) send_op(mk_op(MODE_CREATE, 0, 0, 0, 0, 0));
      // one long chain 0..63 with a block on entry 5, then tail and free of it
      for (n = 0; n < ENTRIES - 1; n++)
         send_op(mk_op(MODE_LINK, n[5:0], n[5:0] + 6'd1, 0, 0, 0));
      write_offset(16'hFFFF);
      send_op(mk_op(MODE_ASSIGN, 5, 0, 0, 16'h0002, 1));  // sum wraps
      send_op(mk_op(MODE_TAIL, 0, 0, 0, 0, 0));
      rsp_stall_en = 1'b0;
      send_op(mk_op(MODE_FREE, 0, 0, 0, 0, 0));
      drain_results();   // sender holds until every result is in
      rsp_stall_en = 1'b1;

      // random part: phases with different offsets
      for (n = 0; n < NUM_RANDOM; n++) begin
         if (n % 115 == 0)
            write_offset((n == 0) ? 16'h0000 : 16'($urandom_range(0, 16'hFFFF)));
         r = $urandom_range(0, 99);
         op.mode = (r < 25) ? MODE_CREATE : (r < 35) ? MODE_TAIL : (r < 45) ? MODE_READ :
                   (r < 68) ? MODE_LINK : (r < 85) ? MODE_ASSIGN : (r < 97) ? MODE_FREE :
                   3'($urandom_range(6, 7));
         op.entry_index = pick_entry();
         op.link_value = ($urandom_range(0, 9) < 8) ? pick_entry()
                                                    : 6'($urandom_range(0, 63));
         op.link_is_end = ($urandom_range(0, 3) == 0);
         op.free_block = 16'($urandom_range(0, 16'hFFFF));
         op.free_block_ok = ($urandom_range(0, 7) != 0);
         send_op(op);
      end
      drain_results();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #100ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
